FILE: rtl/tcw_pkg.sv
// Package for the text console writer: geometry constants, byte codes,
// sequencer states and the structs passed between its modules.
// No dependencies; every other file of the block imports it.
`default_nettype none

package tcw_pkg;

    // Screen geometry.
    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELL_COUNT = COLUMNS * ROWS;

    // Derived widths.
    localparam int ADDR_W   = $clog2(CELL_COUNT);
    localparam int CNT_W    = $clog2(CELL_COUNT + 1);
    localparam int ROW_W    = $clog2(ROWS);
    localparam int COL_W    = $clog2(COLUMNS + 1);

    // Field widths fixed by the channel definitions.
    localparam int CHAR_W   = 8;
    localparam int ATTR_W   = 4;
    localparam int CELL_W   = 16;
    localparam int CURSOR_W = 11;
    localparam int CADDR_W  = 11;
    localparam int WIDE_W   = (CNT_W > CADDR_W) ? CNT_W : CADDR_W;

    localparam logic [ATTR_W-1:0] ATTR_RESET = 4'd7;

    // Operation codes.
    localparam logic OP_PUT  = 1'b0;
    localparam logic OP_READ = 1'b1;

    // Control bytes.
    localparam logic [CHAR_W-1:0] BYTE_NUL       = 8'd0;
    localparam logic [CHAR_W-1:0] BYTE_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] BYTE_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] BYTE_RETURN    = 8'd13;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ_ISSUE,
        ST_READ_TAKE,
        ST_DISPATCH,
        ST_CELL_WRITE,
        ST_SCROLL,
        ST_BS_READ,
        ST_BS_CHECK,
        ST_FIX_READ,
        ST_FIX_CHECK,
        ST_FINISH
    } tcw_state_t;

    // Where the sequencer goes once a scroll is done.
    typedef enum logic [1:0] {
        RET_FIX,
        RET_CHAR,
        RET_ROW_DEC
    } tcw_ret_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [CELL_W-1:0] wdata;
        logic [ADDR_W-1:0] raddr;
    } tcw_mem_req_t;

    typedef struct packed {
        logic                emit;
        logic [CURSOR_W-1:0] cursor;
        logic [CELL_W-1:0]   value;
    } tcw_result_t;

    // Cell index of a row and column, clamped to the last cell.
    function automatic logic [ADDR_W-1:0] cell_index(input logic [ROW_W-1:0] row,
                                                      input logic [COL_W-1:0] col);
        logic [CNT_W-1:0] sum;
        sum = CNT_W'(row) * CNT_W'(COLUMNS) + CNT_W'(col);
        if (sum >= CNT_W'(CELL_COUNT))
        begin
            sum = CNT_W'(CELL_COUNT - 1);
        end
        return sum[ADDR_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: rtl/tcw_channels.sv
// Valid/ready channel interfaces of the text console writer: input items,
// results and the attribute register write channel. Depends on tcw_pkg.
`default_nettype none

interface tcw_item_if
    import tcw_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               op;
    logic [CHAR_W-1:0]  char_byte;
    logic               string_end;
    logic [CADDR_W-1:0] cell_address;

    modport source (output valid, op, char_byte, string_end, cell_address, input ready);
    modport sink   (input valid, op, char_byte, string_end, cell_address, output ready);
endinterface

interface tcw_result_if
    import tcw_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [CURSOR_W-1:0] cursor_position;
    logic [CELL_W-1:0]   cell_value;

    modport source (output valid, cursor_position, cell_value, input ready);
    modport sink   (input valid, cursor_position, cell_value, output ready);
endinterface

interface tcw_cfg_if
    import tcw_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [ATTR_W-1:0] text_attribute;

    modport source (output valid, text_attribute, input ready);
    modport sink   (input valid, text_attribute, output ready);
endinterface

`default_nettype wire

FILE: rtl/tcw_cell_store.sv
// Screen cell memory of the text console writer: one write and one
// registered read port per cycle. Depends on tcw_pkg.
`default_nettype none

module tcw_cell_store
    import tcw_pkg::*;
(
    input  wire logic              clk,
    input  wire tcw_mem_req_t      req,
    output      logic [CELL_W-1:0] rdata
);

    logic [CELL_W-1:0] mem [0:CELL_COUNT-1];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[req.raddr];
    end

endmodule

`default_nettype wire

FILE: rtl/tcw_sequencer.sv
// Sequencer of the text console writer: cursor state, the clearing pass,
// scroll copy, backspace scan and end-of-string fixup. Depends on tcw_pkg
// and tcw_channels.
`default_nettype none

module tcw_sequencer
    import tcw_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    tcw_item_if.sink               item,
    input  wire logic [ATTR_W-1:0] attribute,
    input  wire logic              out_free,
    input  wire logic [CELL_W-1:0] rdata,
    output      tcw_mem_req_t      mem_req,
    output      tcw_result_t       result
);

    tcw_state_t          state_reg, state_next;
    tcw_ret_t            ret_reg, ret_next;
    logic [ROW_W-1:0]    row_reg, row_next;
    logic [COL_W-1:0]    col_reg, col_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [COL_W-1:0]    scan_reg, scan_next;
    logic [CHAR_W-1:0]   ch_reg, ch_next;
    logic                last_reg, last_next;
    logic [CADDR_W-1:0]  addr_reg, addr_next;
    logic [CELL_W-1:0]   value_reg, value_next;

    logic                accept;
    logic [ADDR_W-1:0]   cur_idx;
    logic [ADDR_W-1:0]   scan_idx;
    logic [CELL_W-1:0]   blank;
    logic                is_bs;
    logic                col_full;
    logic                on_bottom;
    logic                fills_last;
    logic                addr_ok;
    logic                scroll_done;
    tcw_state_t          fix_target;

    assign accept      = item.valid && item.ready;
    assign cur_idx     = cell_index(row_reg, col_reg);
    assign scan_idx    = cell_index(row_reg, scan_reg);
    assign blank       = CELL_W'({attribute, 8'h00});
    assign is_bs       = (ch_reg == BYTE_BACKSPACE);
    assign col_full    = (col_reg >= COL_W'(COLUMNS));
    assign on_bottom   = (row_reg == ROW_W'(ROWS - 1));
    assign fills_last  = ((col_reg + COL_W'(1)) == COL_W'(COLUMNS)) && on_bottom;
    assign addr_ok     = WIDE_W'(item.cell_address) < WIDE_W'(CELL_COUNT);
    assign scroll_done = (cnt_reg == CNT_W'(CELL_COUNT));
    assign fix_target  = last_reg ? ST_FIX_READ : ST_FINISH;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (cnt_reg == CNT_W'(CELL_COUNT - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (item.op == OP_READ)
                    begin
                        state_next = addr_ok ? ST_READ_ISSUE : ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_DISPATCH;
                    end
                end
            end
            ST_READ_ISSUE: state_next = ST_READ_TAKE;
            ST_READ_TAKE:  state_next = ST_FINISH;
            ST_DISPATCH:
            begin
                case (ch_reg)
                    BYTE_NEWLINE:   state_next = on_bottom ? ST_SCROLL : fix_target;
                    BYTE_RETURN:    state_next = fix_target;
                    BYTE_NUL:       state_next = fix_target;
                    BYTE_BACKSPACE:
                    begin
                        if (col_reg != '0)
                        begin
                            state_next = ST_CELL_WRITE;
                        end
                        else if (row_reg != '0)
                        begin
                            state_next = ST_BS_READ;
                        end
                        else
                        begin
                            state_next = fix_target;
                        end
                    end
                    default:
                    begin
                        state_next = (col_full && on_bottom) ? ST_SCROLL : ST_CELL_WRITE;
                    end
                endcase
            end
            ST_CELL_WRITE:
            begin
                if (!is_bs && fills_last)
                begin
                    state_next = ST_SCROLL;
                end
                else
                begin
                    state_next = fix_target;
                end
            end
            ST_SCROLL:
            begin
                if (scroll_done)
                begin
                    state_next = (ret_reg == RET_CHAR) ? ST_CELL_WRITE : fix_target;
                end
            end
            ST_BS_READ: state_next = ST_BS_CHECK;
            ST_BS_CHECK:
            begin
                if (rdata[7:0] == BYTE_NUL || scan_reg == COL_W'(COLUMNS - 1))
                begin
                    state_next = ST_CELL_WRITE;
                end
                else
                begin
                    state_next = ST_BS_READ;
                end
            end
            ST_FIX_READ:  state_next = ST_FIX_CHECK;
            ST_FIX_CHECK: state_next = ST_FINISH;
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Cursor, counters and the latched item.
    always_comb
    begin
        ret_next   = ret_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        cnt_next   = cnt_reg;
        scan_next  = scan_reg;
        ch_next    = ch_reg;
        last_next  = last_reg;
        addr_next  = addr_reg;
        value_next = value_reg;
        case (state_reg)
            ST_CLEAR: cnt_next = cnt_reg + CNT_W'(1);
            ST_IDLE:
            begin
                if (accept)
                begin
                    ch_next    = item.char_byte;
                    last_next  = item.string_end;
                    addr_next  = item.cell_address;
                    value_next = '0;
                end
            end
            ST_READ_TAKE: value_next = rdata;
            ST_DISPATCH:
            begin
                case (ch_reg)
                    BYTE_NEWLINE:
                    begin
                        col_next = '0;
                        if (on_bottom)
                        begin
                            cnt_next = '0;
                            ret_next = RET_FIX;
                        end
                        else
                        begin
                            row_next = row_reg + ROW_W'(1);
                        end
                    end
                    BYTE_RETURN: col_next = '0;
                    BYTE_NUL:    col_next = col_reg;
                    BYTE_BACKSPACE:
                    begin
                        if (col_reg != '0)
                        begin
                            col_next = col_reg - COL_W'(1);
                        end
                        else if (row_reg != '0)
                        begin
                            row_next  = row_reg - ROW_W'(1);
                            scan_next = '0;
                        end
                    end
                    default:
                    begin
                        // A character after the last column wraps first.
                        if (col_full)
                        begin
                            col_next = '0;
                            if (on_bottom)
                            begin
                                cnt_next = '0;
                                ret_next = RET_CHAR;
                            end
                            else
                            begin
                                row_next = row_reg + ROW_W'(1);
                            end
                        end
                    end
                endcase
            end
            ST_CELL_WRITE:
            begin
                if (!is_bs)
                begin
                    col_next = col_reg + COL_W'(1);
                    if (fills_last)
                    begin
                        cnt_next = '0;
                        ret_next = RET_ROW_DEC;
                    end
                end
            end
            ST_SCROLL:
            begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (scroll_done && ret_reg == RET_ROW_DEC)
                begin
                    row_next = row_reg - ROW_W'(1);
                end
            end
            ST_BS_CHECK:
            begin
                if (rdata[7:0] == BYTE_NUL || scan_reg == COL_W'(COLUMNS - 1))
                begin
                    col_next = scan_reg;
                end
                else
                begin
                    scan_next = scan_reg + COL_W'(1);
                end
            end
            default: value_next = value_reg;
        endcase
    end

    // Memory requests, handshake and result.
    always_comb
    begin
        item.ready    = (state_reg == ST_IDLE);
        mem_req.we    = 1'b0;
        mem_req.waddr = cur_idx;
        mem_req.wdata = blank;
        mem_req.raddr = cur_idx;
        result.emit   = 1'b0;
        result.cursor = CURSOR_W'(cur_idx);
        result.value  = value_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = cnt_reg[ADDR_W-1:0];
                mem_req.wdata = '0;
            end
            ST_READ_ISSUE: mem_req.raddr = ADDR_W'(addr_reg);
            ST_CELL_WRITE:
            begin
                mem_req.we    = 1'b1;
                mem_req.wdata = is_bs ? blank : (blank | CELL_W'(ch_reg));
            end
            ST_SCROLL:
            begin
                // Read one row ahead, write the previous read one row up;
                // the bottom row is filled with zero.
                if (cnt_reg < CNT_W'(CELL_COUNT - COLUMNS))
                begin
                    mem_req.raddr = ADDR_W'(cnt_reg + CNT_W'(COLUMNS));
                end
                mem_req.we    = (cnt_reg != '0);
                mem_req.waddr = ADDR_W'(cnt_reg - CNT_W'(1));
                mem_req.wdata = (cnt_reg <= CNT_W'(CELL_COUNT - COLUMNS)) ? rdata : '0;
            end
            ST_BS_READ: mem_req.raddr = scan_idx;
            ST_FIX_CHECK: mem_req.we = (rdata[15:8] == 8'h00);
            ST_FINISH: result.emit = out_free;
            default: result.emit = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            ret_reg   <= RET_FIX;
            row_reg   <= '0;
            col_reg   <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_reg  <= scan_next;
        ch_reg    <= ch_next;
        last_reg  <= last_next;
        addr_reg  <= addr_next;
        value_reg <= value_next;
    end

endmodule

`default_nettype wire

FILE: rtl/text_console_writer.sv
// Top level of the text console writer: attribute register, result
// register, sequencer and cell store. Depends on tcw_pkg, tcw_channels,
// tcw_cell_store and tcw_sequencer.
//
//  Channel  | Direction | Payload                              | Accepted when
//  ---------+-----------+--------------------------------------+------------------
//  item     | in        | op, char_byte, string_end,           | valid && ready
//           |           | cell_address                         |
//  result   | out       | cursor_position, cell_value          | valid && ready
//  cfg      | in        | text_attribute                       | valid && ready
//
// One item is handled at a time; item.ready is high only while the sequencer
// is idle. A read issues the cell address, takes the cell value and finishes;
// an address past the last cell finishes at once. A put with string_end set
// adds the end of string fixup. A scroll walks the cell store once through
// its single write and registered read port; a backspace at column 0 scans
// the row above column by column for its first empty cell or last column.
// After reset a clearing pass writes zero to every cell, with item.ready low.
// The result register holds a transfer while result.ready is low; the next
// item may be accepted meanwhile and waits in its last step until the
// register is free. cfg.ready is always high.
`default_nettype none

module text_console_writer
    import tcw_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    tcw_item_if.sink     item,
    tcw_result_if.source result,
    tcw_cfg_if.sink      cfg
);

    logic [ATTR_W-1:0]   attr_reg;
    logic                out_valid_reg;
    logic [CURSOR_W-1:0] out_pos_reg;
    logic [CELL_W-1:0]   out_val_reg;

    logic                out_free;
    logic [CELL_W-1:0]   rdata;
    tcw_mem_req_t        mem_req;
    tcw_result_t         seq_result;

    // The attribute register accepts a write in any cycle.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attr_reg <= ATTR_RESET;
        end
        else if (cfg.valid)
        begin
            attr_reg <= cfg.text_attribute;
        end
    end

    // The result register is free when empty or being emptied this cycle.
    assign out_free = !out_valid_reg || result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (seq_result.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (seq_result.emit)
        begin
            out_pos_reg <= seq_result.cursor;
            out_val_reg <= seq_result.value;
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.cursor_position = out_pos_reg;
    assign result.cell_value      = out_val_reg;

    tcw_sequencer u_sequencer (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .attribute (attr_reg),
        .out_free  (out_free),
        .rdata     (rdata),
        .mem_req   (mem_req),
        .result    (seq_result)
    );

    tcw_cell_store u_cell_store (
        .clk   (clk),
        .req   (mem_req),
        .rdata (rdata)
    );

endmodule

`default_nettype wire

FILE: rtl/tcw_checker.sv
// Port-level checks of the text console writer, bound to the top level.
// Depends on tcw_pkg and text_console_writer.
`default_nettype none

module tcw_checker
    import tcw_pkg::*;
(
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                item_valid,
    input wire logic                item_ready,
    input wire logic                result_valid,
    input wire logic                result_ready,
    input wire logic [CURSOR_W-1:0] cursor_position,
    input wire logic [CELL_W-1:0]   cell_value
);

    // Only one item is in work: ready drops right after a transfer.
    assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && item_ready) |=> !item_ready)
    else $error("item ready stayed high after a transfer");

    // The reported cursor is always a cell of the screen.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (cursor_position <= CURSOR_W'(CELL_COUNT - 1)))
    else $error("cursor position beyond the last cell");

    // A stalled result holds its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_ready) |=>
            (result_valid && $stable(cursor_position) && $stable(cell_value)))
    else $error("stalled result changed");

endmodule

bind text_console_writer tcw_checker u_tcw_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .item_valid      (item.valid),
    .item_ready      (item.ready),
    .result_valid    (result.valid),
    .result_ready    (result.ready),
    .cursor_position (result.cursor_position),
    .cell_value      (result.cell_value)
);

`default_nettype wire
